// ----- src/peer_choke_selector_macros.svh -----
// ---------------------------------------------------------------------------
// Peer choke selector assertion macros
// Shared concurrent assertion forms clocked on i_clk, gated by reset.
// ---------------------------------------------------------------------------
`ifndef PEER_CHOKE_SELECTOR_MACROS_SVH
`define PEER_CHOKE_SELECTOR_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define PCS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A condition that, when seen, must be followed by another in the next cycle.
`define PCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/pcs_pkg.sv -----
// ---------------------------------------------------------------------------
// Peer choke selector package
// Beat types, ranking entry, cell control and the ranking compare.
// ---------------------------------------------------------------------------
`default_nettype none

package pcs_pkg;

    localparam int MAX_PEERS = 64;
    localparam int CNT_W     = $clog2(MAX_PEERS + 1);
    localparam int SLOT_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [6:0]  UNCHOKE_SLOTS_RST = 7'd8;
    localparam logic [15:0] SNUB_SECONDS_RST  = 16'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNCHOKE_SLOTS = 2'd0,
        CFG_SNUB_SECONDS  = 2'd1,
        CFG_SEEDING_MODE  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic        peer_interested;
        logic [15:0] data_age_seconds;
        logic [31:0] peer_rate;
        logic [30:0] random_key;
        logic        last_peer;
    } t_in_beat;

    typedef struct packed {
        logic [SLOT_W-1:0] peer_slot;
        logic              choke;
        logic              last_result;
    } t_out_beat;

    typedef struct packed {
        logic              pref;
        logic [31:0]       rate;
        logic [30:0]       key;
        logic [SLOT_W-1:0] slot;
        logic              interested;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

    // True when a ranks strictly before b; ties leave b (older) first.
    function automatic logic ranks_before(t_entry a, t_entry b);
        logic res;
        if (a.pref != b.pref) begin
            res = a.pref;
        end else if (a.pref) begin
            res = (a.rate > b.rate);
        end else begin
            res = (a.key < b.key);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/pcs_cell.sv -----
// ---------------------------------------------------------------------------
// Peer choke selector ranking cell
// One place of the sorted chain: takes an inserted peer, passes its entry on.
// ---------------------------------------------------------------------------
`default_nettype none

module pcs_cell
    import pcs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_entry    i_new,
    input  wire t_entry    i_prev_entry,
    input  wire logic      i_prev_take,
    input  wire t_entry    i_next_entry,
    input  wire logic      i_beyond,
    output t_entry         o_entry,
    output logic           o_take
);

    t_entry r_entry;
    t_entry n_entry;

    // An empty place always takes the new peer; a filled one only if it ranks ahead.
    assign o_take  = i_beyond || ranks_before(i_new, r_entry);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift) begin
            n_entry = i_next_entry;
        end else if (i_ctl.insert) begin
            if (i_prev_take) begin
                n_entry = i_prev_entry;
            end else if (o_take) begin
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ----- src/peer_choke_selector.sv -----
// ---------------------------------------------------------------------------
// Peer choke selector
// Ranks up to MAX_PEERS peers in a chain of cells and emits one choke beat per ranked peer.
// ---------------------------------------------------------------------------
//
//   channel   direction   handshake                  payload
//   in        input       i_in_valid / o_in_stall    i_in_beat  (t_in_beat)
//   out       output      o_out_valid / i_out_stall  o_out_beat (t_out_beat)
//   cfg       input       i_cfg_we                   i_cfg_idx, i_cfg_data
//
// Each peer beat is taken when the input is not stalled; it is sorted into place in the cell
// chain as it arrives, every cell comparing it with its own entry at once.
// After the beat marked last_peer the input is stalled while the
// chain shifts its entries out through cell 0, one result beat per cycle.
// Output stalls pause the shift; the output register lets the next set load
// while the final result still waits. Reset is synchronous and needs no
// clearing pass: a fill count marks which cells hold peers.
// ---------------------------------------------------------------------------
`default_nettype none

`include "peer_choke_selector_macros.svh"

module peer_choke_selector
    import pcs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_beat             i_in_beat,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_beat                 o_out_beat,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [SLOT_W-1:0] r_idx;
    logic              r_open;
    logic              r_out_valid;
    t_out_beat         r_out;

    logic [6:0]  r_unchoke_slots;
    logic [15:0] r_snub_seconds;
    logic        r_seeding_mode;

    t_entry    new_entry;
    t_cell_ctl cell_ctl;
    t_entry    cell_entry [MAX_PEERS];
    logic      cell_take  [MAX_PEERS];
    logic      in_accept;
    logic      set_full;
    logic      out_free;
    logic      do_shift;
    logic      choke;
    logic      in_slots;

    // Configuration registers; writes to an unknown index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unchoke_slots <= UNCHOKE_SLOTS_RST;
            r_snub_seconds  <= SNUB_SECONDS_RST;
            r_seeding_mode  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_UNCHOKE_SLOTS: r_unchoke_slots <= i_cfg_data[6:0];
                CFG_SNUB_SECONDS:  r_snub_seconds  <= i_cfg_data[15:0];
                CFG_SEEDING_MODE:  r_seeding_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = (r_state == ST_EMIT);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign set_full   = (r_count == CNT_W'(MAX_PEERS));

    // A peer is preferred when it is interested and has sent data recently.
    always_comb begin
        new_entry.pref = i_in_beat.peer_interested &&
                         (i_in_beat.data_age_seconds <= r_snub_seconds);
        new_entry.rate       = i_in_beat.peer_rate;
        new_entry.key        = i_in_beat.random_key;
        new_entry.slot       = r_count[SLOT_W-1:0];
        new_entry.interested = i_in_beat.peer_interested;
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign do_shift = (r_state == ST_EMIT) && out_free;

    assign cell_ctl.insert = in_accept && !set_full;
    assign cell_ctl.shift  = do_shift;

    for (genvar gi = 0; gi < MAX_PEERS; gi++) begin : g_cell
        pcs_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_new        (new_entry),
            .i_prev_entry ((gi == 0) ? new_entry : cell_entry[(gi == 0) ? 0 : gi - 1]),
            .i_prev_take  ((gi == 0) ? 1'b0 : cell_take[(gi == 0) ? 0 : gi - 1]),
            .i_next_entry ((gi == MAX_PEERS - 1) ? t_entry'('0)
                           : cell_entry[(gi == MAX_PEERS - 1) ? gi : gi + 1]),
            .i_beyond     (r_count <= CNT_W'(gi)),
            .o_entry      (cell_entry[gi]),
            .o_take       (cell_take[gi])
        );
    end

    // The head of the chain is the next peer in rank order. The first
    // unchoke_slots peers are unchoked, then peers stay unchoked up to and
    // including the first interested one; in seeding mode no peer is choked.
    assign in_slots = ({1'b0, r_idx} < r_unchoke_slots);
    always_comb begin
        if (r_seeding_mode || in_slots || r_open) begin
            choke = 1'b0;
        end else begin
            choke = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_idx       <= '0;
            r_open      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // A taken beat frees the output register unless a new one moves in.
            if (r_out_valid && !i_out_stall && !do_shift) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (in_accept) begin
                        if (!set_full) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (i_in_beat.last_peer) begin
                            r_state <= ST_EMIT;
                            r_idx   <= '0;
                            r_open  <= 1'b1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out.peer_slot   <= cell_entry[0].slot;
                        r_out.choke       <= choke;
                        r_out.last_result <= (r_count == CNT_W'(1));
                        r_count           <= r_count - CNT_W'(1);
                        r_idx             <= r_idx + SLOT_W'(1);
                        if (!r_seeding_mode && !in_slots && cell_entry[0].interested) begin
                            r_open <= 1'b0;
                        end
                        if (r_count == CNT_W'(1)) begin
                            r_state <= ST_LOAD;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    `PCS_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(MAX_PEERS), "peer count overflow")
    `PCS_ASSERT_ALWAYS(a_emit_nonempty, (r_state != ST_EMIT) || (r_count != '0), "empty emit")
    `PCS_ASSERT_NEXT(a_last_starts, in_accept && i_in_beat.last_peer, r_state == ST_EMIT, "no emit")
    `PCS_ASSERT_NEXT(a_out_hold, r_out_valid && i_out_stall, r_out_valid && $stable(r_out), "moved")

endmodule

`default_nettype wire
